// ===== hdl/spd_pkg.sv =====
// Shared constants, codes and types of the sensor packet decoder.
// No dependencies.
package spd_pkg;
	localparam int MAX_DEVICES_DEF = 8;
	localparam logic [31:0] STALE_TIMEOUT_RST = 32'd5000;

	localparam int PKT_LAST    = 31;
	localparam int PAYLOAD_LEN = 31;
	localparam int POS_W       = 5;
	localparam int NUM_SAMPLES = 8;
	localparam int SIDX_W      = 3;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 240;

	localparam logic [1:0] ST_KNOWN = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic [12:0] BATT_BASE  = 13'd2000;
	localparam logic [3:0]  BATT_SCALE = 4'd10;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
	} spd_tbl_rsp_t;
endpackage

// ===== hdl/spd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module spd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/spd_table.sv =====
// Device table sequencer: stale eviction with compaction, then lookup or add (full when no slot is free).
// Uses spd_pkg and one spd_ram holding {last_seen, device_id} per entry.
module spd_table import spd_pkg::*; #(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  id,
	input  logic [31:0]  now,
	input  logic [31:0]  timeout,
	output logic         done,
	output spd_tbl_rsp_t rsp
);
	localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CW = $clog2(MAX_DEVICES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEVICES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CRD  = 3'd1;
	localparam logic [2:0] S_CEV  = 3'd2;
	localparam logic [2:0] S_LRD  = 3'd3;
	localparam logic [2:0] S_LEV  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q, rd_q, wr_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [63:0]   wdata, rdata;
	logic          stale;

	spd_ram #(.WIDTH(64), .DEPTH(MAX_DEVICES), .AW(AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	// subtract-and-compare unit of the stale sweep
	assign stale = (now - rdata[63:32]) > timeout;

	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_CEV: begin
				we = !stale;
			end
			S_LEV: begin
				we    = (rdata[31:0] == id);
				waddr = rd_q[AW-1:0];
				wdata = {now, id};
			end
			S_LRD: begin
				we    = (rd_q == count_q) && (count_q < MAX_CNT);
				waddr = count_q[AW-1:0];
				wdata = {now, id};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			done    <= 1'b0;
			rsp     <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_q    <= '0;
						wr_q    <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					if (rd_q == count_q) begin
						count_q <= wr_q;
						rd_q    <= '0;
						state_q <= S_LRD;
					end else begin
						state_q <= S_CEV;
					end
				end
				S_CEV: begin
					if (!stale) begin
						wr_q <= wr_q + 1'b1;
					end
					rd_q    <= rd_q + 1'b1;
					state_q <= S_CRD;
				end
				S_LRD: begin
					if (rd_q == count_q) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
						if (count_q < MAX_CNT) begin
							rsp.status <= ST_NEW;
							rsp.slot   <= 3'(count_q);
							count_q    <= count_q + 1'b1;
						end else begin
							rsp.status <= ST_FULL;
							rsp.slot   <= 3'd0;
						end
					end else begin
						state_q <= S_LEV;
					end
				end
				S_LEV: begin
					if (rdata[31:0] == id) begin
						rsp.status <= ST_KNOWN;
						rsp.slot   <= 3'(rd_q);
						done       <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						rd_q    <= rd_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/sensor_packet_decoder.sv =====
// Top level of the sensor packet decoder: byte capture, checksum, result beats.
// Uses spd_pkg and spd_table (which holds spd_ram).
//
// Takes a 32-byte radio packet one beat per byte; byte 0 is dropped and bytes
// 1..31 are payload 0..30. Non-final bytes are accepted back to back. On the
// final byte the checksum is compared; a bad packet gives one beat with status
// 3. A good packet runs the device-table walk: a stale sweep that reads and
// then checks each entry in turn, and a lookup that reads and then compares
// each entry, since the table RAM has a single read port; then eight result
// beats, one per raw sample. s_axis_tready is low from the final byte until
// the last result beat has been taken. The config port is always ready and
// must be written only while the block is idle.
module sensor_packet_decoder import spd_pkg::*; #(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], now_time[39:8]
	input  logic                   s_axis_tuser,  // packet_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// slot[2:0], sender_id[34:3], sequence_id[42:35], battery_mv[55:43],
	// average_level[68:56], spectrum_words[132:69], muscle_level[150:133],
	// orientation_words[214:151], sample_index[217:215], sample_value[233:218]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser,  // status
	output logic                   m_axis_tlast,  // last_result
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [31:0]            cfg_data
);
	localparam logic [1:0] T_IN   = 2'd0;
	localparam logic [1:0] T_WALK = 2'd1;
	localparam logic [1:0] T_OUT  = 2'd2;

	logic [1:0]       state_q;
	logic [31:0]      timeout_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       pay_q [PAYLOAD_LEN];
	logic [31:0]      id_q, now_q;
	logic [SIDX_W-1:0] k_q;
	spd_tbl_rsp_t     rsp_q, tbl_rsp;
	logic             tbl_start, tbl_done;

	logic             acc;
	logic [7:0]       in_byte;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       sum_eff;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == T_IN);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign in_byte       = s_axis_tdata[7:0];
	// a start flag restarts position and sum from this byte
	assign pos_eff       = s_axis_tuser ? '0 : pos_q;
	assign sum_eff       = s_axis_tuser ? '0 : sum_q;
	assign tbl_start     = acc && (pos_eff == POS_W'(PKT_LAST)) && (sum_eff == in_byte);

	// time stamp held from the final byte for the whole walk
	spd_table #(.MAX_DEVICES(MAX_DEVICES)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tbl_start),
		.id     ({pay_q[2], pay_q[3], pay_q[4], pay_q[5]}),
		.now    (now_q),
		.timeout(timeout_q),
		.done   (tbl_done),
		.rsp    (tbl_rsp)
	);

	// ---- decoded fields of the stored packet
	logic [15:0] bin0, bin1, bin2, bin3, qw, raw0, sval;
	logic [12:0] batt, avg;
	logic [15:0] sq;
	logic [17:0] muscle;
	logic [7:0]  delta;
	logic        neg;
	logic [SIDX_W-1:0] kn;
	logic [OUT_TDATA_W-1:0] beat;

	always_comb begin
		bin0   = {pay_q[7], 8'd0};
		bin1   = {pay_q[9], pay_q[10]};
		bin2   = {pay_q[11], pay_q[12]};
		bin3   = {pay_q[13], pay_q[14]};
		qw     = {pay_q[15], pay_q[16]};
		raw0   = {pay_q[20], pay_q[21]};
		batt   = BATT_BASE + 13'(BATT_SCALE) * 13'(pay_q[6]);
		sq     = 16'(pay_q[8]) * 16'(pay_q[8]);
		avg    = 13'(sq >> 3);
		muscle = 18'(bin2) + {1'b0, bin3, 1'b0};
		kn     = (state_q == T_OUT) ? k_q + 1'b1 : '0;
		delta  = pay_q[POS_W'(21) + POS_W'(kn)];
		neg    = pay_q[29][3'(3'd7 - kn)];
		if (kn == '0) begin
			sval = raw0;
		end else if (neg) begin
			sval = raw0 - 16'(delta);
		end else begin
			sval = raw0 + 16'(delta);
		end
		beat = {6'd0, sval, kn,
			pay_q[19], 8'd0, pay_q[18], 8'd0, pay_q[17], 8'd0, qw,
			muscle, bin3, bin2, bin1, bin0, avg, batt, pay_q[0], id_q, rsp_q.slot};
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (pos_eff == POS_W'(PKT_LAST)) begin
				pay_q[PAYLOAD_LEN-1] <= in_byte;
				id_q  <= {pay_q[2], pay_q[3], pay_q[4], pay_q[5]};
				now_q <= s_axis_tdata[39:8];
			end else if (pos_eff != '0) begin
				pay_q[pos_eff - 1'b1] <= in_byte;
			end
		end
		if (tbl_done) begin
			rsp_q <= tbl_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IN;
			timeout_q     <= STALE_TIMEOUT_RST;
			pos_q         <= '0;
			sum_q         <= '0;
			k_q           <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			case (state_q)
				T_IN: begin
					if (acc) begin
						if (pos_eff == POS_W'(PKT_LAST)) begin
							pos_q <= '0;
							sum_q <= '0;
							if (sum_eff != in_byte) begin
								// bad checksum: single all-zero beat
								m_axis_tvalid <= 1'b1;
								m_axis_tdata  <= '0;
								m_axis_tuser  <= ST_BAD;
								m_axis_tlast  <= 1'b1;
								state_q       <= T_OUT;
							end else begin
								state_q <= T_WALK;
							end
						end else begin
							if (pos_eff != '0) begin
								sum_q <= sum_eff + in_byte;
							end else begin
								sum_q <= sum_eff;
							end
							pos_q <= pos_eff + 1'b1;
						end
					end
				end
				T_WALK: begin
					if (tbl_done) begin
						// rsp_q lands this edge; first beat built next cycle
						k_q     <= '1;
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (!m_axis_tvalid) begin
						// first beat of a good packet
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= beat;
						m_axis_tuser  <= rsp_q.status;
						m_axis_tlast  <= 1'b0;
						k_q           <= '0;
					end else if (m_axis_tready) begin
						if (m_axis_tlast) begin
							m_axis_tvalid <= 1'b0;
							m_axis_tlast  <= 1'b0;
							state_q       <= T_IN;
						end else begin
							m_axis_tdata <= beat;
							m_axis_tlast <= (k_q + 1'b1) == SIDX_W'(NUM_SAMPLES - 1);
							k_q          <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= T_IN;
			endcase
		end
	end
endmodule
